// ===== design/rmrs_pkg.sv =====
// rmrs_pkg: shared types, operand codes, saturating helpers and microcode for the solver
// used by rmrs_ctrl, rmrs_datapath and the top level; no dependencies

package rmrs_pkg;

   // widths; TagW, WordW, IterW and StatW are fixed by the stream format
   localparam int TagW    = 16;
   localparam int WordW   = 32;
   localparam int TolW    = 16;
   localparam int FxW     = 64;
   localparam int IterW   = 6;
   localparam int StatW   = 2;
   localparam int PcW     = 7;
   localparam int CodeW   = 5;
   localparam int MemAw   = 4;
   localparam int RootTop = 39;
   localparam int DivLast = 95;

   // csr indexes
   localparam logic [1:0] CSR_HEAT_CAP  = 2'd0;
   localparam logic [1:0] CSR_RAD_CONST = 2'd1;
   localparam logic [1:0] CSR_TIME_STEP = 2'd2;
   localparam logic [1:0] CSR_TOLERANCE = 2'd3;

   localparam logic [WordW-1:0] HEAT_CAP_RST  = 32'd65536;
   localparam logic [WordW-1:0] RAD_CONST_RST = 32'd65536;
   localparam logic [WordW-1:0] TIME_STEP_RST = 32'd655;
   localparam logic [TolW-1:0]  TOLERANCE_RST = 16'd66;

   // result status codes
   localparam logic [StatW-1:0] ST_CONVERGED = 2'd0;
   localparam logic [StatW-1:0] ST_LIMIT     = 2'd1;
   localparam logic [StatW-1:0] ST_SINGULAR  = 2'd2;

   localparam logic [FxW-1:0] FX_ONE = 64'h0000_0001_0000_0000;
   localparam logic [FxW-1:0] FX_SAT = '1;

   // micro operations
   typedef enum logic [3:0] {
      OP_ADD, OP_MUL, OP_DIV, OP_ABSDIF, OP_LT, OP_RINIT, OP_RCAND, OP_RSTEP,
      OP_RGET, OP_ITINC, OP_ITCHK, OP_ST0, OP_ST1, OP_JMP, OP_JT, OP_END
   } op_type;

   // scratch file entries (some shared between values that never live together)
   localparam logic [CodeW-1:0] M_S     = 5'd0;
   localparam logic [CodeW-1:0] M_DEN   = 5'd1;
   localparam logic [CodeW-1:0] M_MU    = 5'd2;
   localparam logic [CodeW-1:0] M_E2    = 5'd3;
   localparam logic [CodeW-1:0] M_D     = 5'd4;
   localparam logic [CodeW-1:0] M_AT4   = 5'd5;
   localparam logic [CodeW-1:0] M_J2    = 5'd6;
   localparam logic [CodeW-1:0] M_K     = 5'd7;
   localparam logic [CodeW-1:0] M_B2    = 5'd8;
   localparam logic [CodeW-1:0] M_DET   = 5'd9;
   localparam logic [CodeW-1:0] M_X     = 5'd10;
   localparam logic [CodeW-1:0] M_Y     = 5'd11;
   localparam logic [CodeW-1:0] M_TPREV = 5'd12;
   localparam logic [CodeW-1:0] M_TH    = 5'd13;
   localparam logic [CodeW-1:0] M_P     = 5'd14;
   localparam logic [CodeW-1:0] M_C     = 5'd15;
   localparam logic [CodeW-1:0] M_NE    = M_P;
   localparam logic [CodeW-1:0] M_NT    = M_C;
   localparam logic [CodeW-1:0] M_T2    = M_K;

   // dedicated sources, top bit set
   localparam logic [CodeW-1:0] S_ZERO = 5'd16;
   localparam logic [CodeW-1:0] S_SAT  = 5'd17;
   localparam logic [CodeW-1:0] S_ONE  = 5'd18;
   localparam logic [CodeW-1:0] S_EJ   = 5'd19;
   localparam logic [CodeW-1:0] S_TJ   = 5'd20;
   localparam logic [CodeW-1:0] S_SIG  = 5'd21;
   localparam logic [CodeW-1:0] S_EPS  = 5'd22;
   localparam logic [CodeW-1:0] S_CV   = 5'd23;
   localparam logic [CodeW-1:0] S_RA   = 5'd24;
   localparam logic [CodeW-1:0] S_DT   = 5'd25;
   localparam logic [CodeW-1:0] S_TOL  = 5'd26;
   localparam logic [CodeW-1:0] S_EP   = 5'd27;
   localparam logic [CodeW-1:0] S_TP   = 5'd28;

   typedef struct packed {
      op_type           op;
      logic [CodeW-1:0] a;
      logic [CodeW-1:0] b;
      logic [CodeW-1:0] dst;
      logic [PcW-1:0]   tgt;
   } uinst_type;

   // controller to datapath
   typedef struct packed {
      logic             load;
      logic             start;
      op_type           op;
      logic [CodeW-1:0] a;
      logic [CodeW-1:0] b;
      logic [CodeW-1:0] dst;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic done;
      logic flag;
   } sts_type;

   typedef struct packed {
      logic [TagW-1:0]  cell_id;
      logic [WordW-1:0] energy_out;
      logic [WordW-1:0] temperature_out;
      logic [IterW-1:0] iterations;
      logic [StatW-1:0] status;
   } result_type;

   // saturating q32.32 add
   function automatic logic [FxW-1:0] fx_add(input logic [FxW-1:0] x, input logic [FxW-1:0] y);
      logic [FxW:0] s;
      s = {1'b0, x} + {1'b0, y};
      return s[FxW] ? FX_SAT : s[FxW-1:0];
   endfunction

   // q32.32 to q16.16, saturating
   function automatic logic [WordW-1:0] to_out(input logic [FxW-1:0] v);
      return (v[FxW-1:48] != '0) ? '1 : v[47:16];
   endfunction

   function automatic uinst_type ui(input op_type op, input logic [CodeW-1:0] a,
                                    input logic [CodeW-1:0] b, input logic [CodeW-1:0] dst,
                                    input logic [PcW-1:0] tgt);
      uinst_type u;
      u.op = op; u.a = a; u.b = b; u.dst = dst; u.tgt = tgt;
      return u;
   endfunction

   localparam logic [PcW-1:0] L_DSAT  = 7'd14;
   localparam logic [PcW-1:0] L_POW   = 7'd15;
   localparam logic [PcW-1:0] L_LOOP  = 7'd19;
   localparam logic [PcW-1:0] L_ROOT  = 7'd37;
   localparam logic [PcW-1:0] L_CONV  = 7'd64;
   localparam logic [PcW-1:0] L_LIMIT = 7'd66;
   localparam logic [PcW-1:0] L_END   = 7'd67;

   // solver microprogram; arithmetic ops set the flag when the result is zero
   function automatic uinst_type ucode(input logic [PcW-1:0] pc);
      uinst_type u;
      unique case (pc)
         // start from the inputs, bail out on zero temperature
         7'd0:  u = ui(OP_ADD,   S_EJ,  S_ZERO, S_EP,    '0);
         7'd1:  u = ui(OP_ADD,   S_TJ,  S_ZERO, S_TP,    '0);
         7'd2:  u = ui(OP_JT,    '0,    '0,     '0,      L_END);
         // first linearisation 1/(4 T^3)
         7'd3:  u = ui(OP_MUL,   S_TJ,  S_TJ,   M_X,     '0);
         7'd4:  u = ui(OP_MUL,   M_X,   S_TJ,   M_S,     '0);
         7'd5:  u = ui(OP_ADD,   M_S,   M_S,    M_X,     '0);
         7'd6:  u = ui(OP_ADD,   M_X,   M_X,    M_DEN,   '0);
         7'd7:  u = ui(OP_JT,    '0,    '0,     '0,      L_END);
         7'd8:  u = ui(OP_DIV,   S_ONE, M_DEN,  M_MU,    '0);
         // coupling d = sigma dt / eps^2
         7'd9:  u = ui(OP_MUL,   S_EPS, S_EPS,  M_E2,    '0);
         7'd10: u = ui(OP_JT,    '0,    '0,     '0,      L_DSAT);
         7'd11: u = ui(OP_MUL,   S_SIG, S_DT,   M_X,     '0);
         7'd12: u = ui(OP_DIV,   M_X,   M_E2,   M_D,     '0);
         7'd13: u = ui(OP_JMP,   '0,    '0,     '0,      L_POW);
         7'd14: u = ui(OP_ADD,   S_SAT, S_ZERO, M_D,     '0);
         // a T^4 and T^2 of the input
         7'd15: u = ui(OP_MUL,   S_TJ,  S_TJ,   M_X,     '0);
         7'd16: u = ui(OP_MUL,   M_X,   M_X,    M_Y,     '0);
         7'd17: u = ui(OP_MUL,   S_RA,  M_Y,    M_AT4,   '0);
         7'd18: u = ui(OP_MUL,   S_TJ,  S_TJ,   M_J2,    '0);
         // pass: determinant
         7'd19: u = ui(OP_MUL,   S_CV,  M_MU,   M_K,     '0);
         7'd20: u = ui(OP_MUL,   M_K,   M_AT4,  M_B2,    '0);
         7'd21: u = ui(OP_ADD,   M_K,   M_D,    M_X,     '0);
         7'd22: u = ui(OP_MUL,   M_K,   M_D,    M_Y,     '0);
         7'd23: u = ui(OP_ADD,   M_X,   M_Y,    M_DET,   '0);
         7'd24: u = ui(OP_JT,    '0,    '0,     '0,      L_END);
         // numerators
         7'd25: u = ui(OP_MUL,   S_EJ,  M_X,    M_Y,     '0);
         7'd26: u = ui(OP_MUL,   M_B2,  M_D,    M_X,     '0);
         7'd27: u = ui(OP_ADD,   M_Y,   M_X,    M_NE,    '0);
         7'd28: u = ui(OP_ADD,   S_ONE, M_D,    M_X,     '0);
         7'd29: u = ui(OP_MUL,   M_B2,  M_X,    M_Y,     '0);
         7'd30: u = ui(OP_MUL,   S_EJ,  M_D,    M_X,     '0);
         7'd31: u = ui(OP_ADD,   M_Y,   M_X,    M_NT,    '0);
         7'd32: u = ui(OP_ADD,   S_TP,  S_ZERO, M_TPREV, '0);
         7'd33: u = ui(OP_DIV,   M_NE,  M_DET,  S_EP,    '0);
         7'd34: u = ui(OP_DIV,   M_NT,  M_DET,  M_TH,    '0);
         7'd35: u = ui(OP_DIV,   M_TH,  S_RA,   M_X,     '0);
         // fourth root, one bit per round
         7'd36: u = ui(OP_RINIT, '0,    '0,     '0,      '0);
         7'd37: u = ui(OP_RCAND, '0,    '0,     M_C,     '0);
         7'd38: u = ui(OP_MUL,   M_C,   M_C,    M_Y,     '0);
         7'd39: u = ui(OP_MUL,   M_Y,   M_Y,    M_P,     '0);
         7'd40: u = ui(OP_RSTEP, M_P,   M_X,    '0,      '0);
         7'd41: u = ui(OP_JT,    '0,    '0,     '0,      L_ROOT);
         7'd42: u = ui(OP_RGET,  '0,    '0,     S_TP,    '0);
         // convergence check
         7'd43: u = ui(OP_ADD,   M_TPREV, S_ZERO, M_Y,   '0);
         7'd44: u = ui(OP_JT,    '0,    '0,     '0,      L_END);
         7'd45: u = ui(OP_ABSDIF, S_TP, M_TPREV, M_Y,    '0);
         7'd46: u = ui(OP_DIV,   M_Y,   M_TPREV, M_Y,    '0);
         7'd47: u = ui(OP_LT,    M_Y,   S_TOL,  '0,      '0);
         7'd48: u = ui(OP_JT,    '0,    '0,     '0,      L_CONV);
         7'd49: u = ui(OP_ITCHK, '0,    '0,     '0,      '0);
         7'd50: u = ui(OP_JT,    '0,    '0,     '0,      L_LIMIT);
         // new linearisation factor
         7'd51: u = ui(OP_MUL,   S_TP,  S_TP,   M_T2,    '0);
         7'd52: u = ui(OP_MUL,   M_T2,  S_TP,   M_X,     '0);
         7'd53: u = ui(OP_MUL,   S_TJ,  M_T2,   M_Y,     '0);
         7'd54: u = ui(OP_ADD,   M_X,   M_Y,    M_S,     '0);
         7'd55: u = ui(OP_MUL,   S_TP,  M_J2,   M_X,     '0);
         7'd56: u = ui(OP_MUL,   M_J2,  S_TJ,   M_Y,     '0);
         7'd57: u = ui(OP_ADD,   M_X,   M_Y,    M_X,     '0);
         7'd58: u = ui(OP_ADD,   M_S,   M_X,    M_S,     '0);
         7'd59: u = ui(OP_MUL,   S_RA,  M_S,    M_DEN,   '0);
         7'd60: u = ui(OP_JT,    '0,    '0,     '0,      L_END);
         7'd61: u = ui(OP_DIV,   S_ONE, M_DEN,  M_MU,    '0);
         7'd62: u = ui(OP_ITINC, '0,    '0,     '0,      '0);
         7'd63: u = ui(OP_JMP,   '0,    '0,     '0,      L_LOOP);
         // exits
         7'd64: u = ui(OP_ST0,   '0,    '0,     '0,      '0);
         7'd65: u = ui(OP_JMP,   '0,    '0,     '0,      L_END);
         7'd66: u = ui(OP_ST1,   '0,    '0,     '0,      '0);
         default: u = ui(OP_END, '0,    '0,     '0,      '0);
      endcase
      return u;
   endfunction

endpackage

// ===== design/rmrs_ctrl.sv =====
// rmrs_ctrl: microprogram sequencer and stream handshake control
// depends on rmrs_pkg; drives rmrs_datapath through cmd_type / sts_type

module rmrs_ctrl
   import rmrs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd,
   input  sts_type sts
);

   typedef enum logic [1:0] {C_IDLE, C_ISSUE, C_WAIT, C_RESP} state_type;

   state_type        state_ff, state_in;
   logic [PcW-1:0]   pc_ff, pc_in;
   logic             start_ff, start_in;
   op_type           op_ff, op_in;
   logic [CodeW-1:0] a_ff, a_in, b_ff, b_in, dst_ff, dst_in;
   uinst_type        inst;

   assign inst = ucode(pc_ff);

   // sequencing
   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      start_in = 1'b0;
      op_in    = op_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      dst_in   = dst_ff;
      unique case (state_ff)
         C_IDLE: begin
            if (req_tvalid) begin
               pc_in    = '0;
               state_in = C_ISSUE;
            end
         end
         C_ISSUE: begin
            unique case (inst.op)
               OP_JMP: pc_in = inst.tgt;
               OP_JT:  pc_in = sts.flag ? inst.tgt : pc_ff + 1'b1;
               OP_END: state_in = C_RESP;
               default: begin
                  start_in = 1'b1;
                  op_in    = inst.op;
                  a_in     = inst.a;
                  b_in     = inst.b;
                  dst_in   = inst.dst;
                  state_in = C_WAIT;
               end
            endcase
         end
         C_WAIT: begin
            if (sts.done) begin
               pc_in    = pc_ff + 1'b1;
               state_in = C_ISSUE;
            end
         end
         C_RESP: begin
            if (rsp_tready) state_in = C_IDLE;
         end
         default: state_in = C_IDLE;
      endcase
   end

   // state and registered command
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         start_ff <= 1'b0;
         pc_ff    <= '0;
         op_ff    <= OP_END;
         a_ff     <= '0;
         b_ff     <= '0;
         dst_ff   <= '0;
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
         pc_ff    <= pc_in;
         op_ff    <= op_in;
         a_ff     <= a_in;
         b_ff     <= b_in;
         dst_ff   <= dst_in;
      end
   end

   assign req_tready = (state_ff == C_IDLE);
   assign rsp_tvalid = (state_ff == C_RESP);

   always_comb begin
      cmd.load  = req_tvalid && (state_ff == C_IDLE);
      cmd.start = start_ff;
      cmd.op    = op_ff;
      cmd.a     = a_ff;
      cmd.b     = b_ff;
      cmd.dst   = dst_ff;
   end

endmodule

// ===== design/rmrs_datapath.sv =====
// rmrs_datapath: csr registers, cell registers, scratch file, shared 32x32 multiplier,
// bit-serial divider and fourth-root bit logic; depends on rmrs_pkg

module rmrs_datapath
   import rmrs_pkg::*;
#(
   parameter int MAX_ITER = 25
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wen,
   input  logic [1:0]       csr_index,
   input  logic [WordW-1:0] csr_wdata,
   input  logic [TagW-1:0]  cell_tag,
   input  logic [WordW-1:0] energy_in,
   input  logic [WordW-1:0] temperature_in,
   input  logic [WordW-1:0] absorption,
   input  logic [WordW-1:0] scaling_eps,
   input  cmd_type          cmd,
   output sts_type          sts,
   output result_type       res
);

   typedef enum logic [2:0] {D_IDLE, D_FB, D_LB, D_EXEC, D_MUL, D_DIV} state_type;

   localparam logic [IterW-1:0] IterMax = IterW'(MAX_ITER);

   state_type        state_ff, state_in;
   op_type           op_ff, op_in;
   logic [CodeW-1:0] b_ff, b_in, dst_ff, dst_in;
   logic [CodeW-1:0] a_hold_ff;
   logic [FxW-1:0]   rd_q_ff, opa_ff, opa_in, opb_ff, opb_in;
   logic [FxW-1:0]   acc_ff, acc_in, prod_ff, prod_in;
   logic [2:0]       mcnt_ff, mcnt_in;
   logic [FxW-1:0]   rem_ff, rem_in, q_ff, q_in, num_ff, num_in;
   logic [6:0]       dcnt_ff, dcnt_in;
   logic [RootTop:0] rt_ff, rt_in;
   logic [5:0]       rb_ff, rb_in;
   logic [IterW-1:0] iter_ff, iter_in;
   logic [StatW-1:0] status_ff, status_in;
   logic             flag_ff, flag_in, done_ff, done_in;
   logic [TagW-1:0]  tag_ff;
   logic [WordW-1:0] ej_ff, tj_ff, sig_ff, eps_ff;
   logic [FxW-1:0]   ep_ff, ep_in, tp_ff, tp_in;
   logic [WordW-1:0] cv_ff, ra_ff, dt_ff;
   logic [TolW-1:0]  tol_ff;

   logic [FxW-1:0]   mem [2**MemAw];
   logic [MemAw-1:0] rd_addr;
   logic             wr_en;
   logic [CodeW-1:0] wr_dst;
   logic [FxW-1:0]   wr_data;
   logic [CodeW-1:0] sel_code;
   logic [FxW-1:0]   sel_data;
   logic [WordW-1:0] mul_a, mul_b;
   logic [FxW-1:0]   rbit, r2;
   logic             carry, take;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff  <= HEAT_CAP_RST;
         ra_ff  <= RAD_CONST_RST;
         dt_ff  <= TIME_STEP_RST;
         tol_ff <= TOLERANCE_RST;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_HEAT_CAP:  cv_ff  <= csr_wdata;
            CSR_RAD_CONST: ra_ff  <= csr_wdata;
            CSR_TIME_STEP: dt_ff  <= csr_wdata;
            CSR_TOLERANCE: tol_ff <= csr_wdata[TolW-1:0];
            default:       cv_ff  <= cv_ff;
         endcase
      end
   end

   // cell capture at the input beat
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tag_ff <= cell_tag;
         ej_ff  <= energy_in;
         tj_ff  <= temperature_in;
         sig_ff <= absorption;
         eps_ff <= scaling_eps;
      end
   end

   // operand source select, q16.16 values widened to q32.32
   assign sel_code = (state_ff == D_FB) ? a_hold_ff : b_ff;

   always_comb begin
      unique case (sel_code)
         S_ZERO:  sel_data = '0;
         S_SAT:   sel_data = FX_SAT;
         S_ONE:   sel_data = FX_ONE;
         S_EJ:    sel_data = {16'b0, ej_ff, 16'b0};
         S_TJ:    sel_data = {16'b0, tj_ff, 16'b0};
         S_SIG:   sel_data = {16'b0, sig_ff, 16'b0};
         S_EPS:   sel_data = {16'b0, eps_ff, 16'b0};
         S_CV:    sel_data = {16'b0, cv_ff, 16'b0};
         S_RA:    sel_data = {16'b0, ra_ff, 16'b0};
         S_DT:    sel_data = {16'b0, dt_ff, 16'b0};
         S_TOL:   sel_data = {32'b0, tol_ff, 16'b0};
         S_EP:    sel_data = ep_ff;
         S_TP:    sel_data = tp_ff;
         default: sel_data = rd_q_ff;
      endcase
   end

   // scratch file, one write and one registered read port
   assign rd_addr = (state_ff == D_IDLE) ? cmd.a[MemAw-1:0] : b_ff[MemAw-1:0];

   always_ff @(posedge clock) begin
      rd_q_ff <= mem[rd_addr];
      if (wr_en && !wr_dst[CodeW-1]) mem[wr_dst[MemAw-1:0]] <= wr_data;
   end

   // shared multiplier, one partial product per cycle
   always_comb begin
      unique case (mcnt_ff[1:0])
         2'd0: begin mul_a = opa_ff[63:32]; mul_b = opb_ff[63:32]; end
         2'd1: begin mul_a = opa_ff[63:32]; mul_b = opb_ff[31:0];  end
         2'd2: begin mul_a = opa_ff[31:0];  mul_b = opb_ff[63:32]; end
         default: begin mul_a = opa_ff[31:0]; mul_b = opb_ff[31:0]; end
      endcase
   end

   // divider step and root candidate bit
   always_comb begin
      carry = rem_ff[FxW-1];
      r2    = {rem_ff[FxW-2:0], num_ff[FxW-1]};
      take  = carry || (r2 >= opb_ff);
      rbit  = FxW'(1) << rb_ff;
   end

   // operation sequencing
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      b_in      = b_ff;
      dst_in    = dst_ff;
      opa_in    = opa_ff;
      opb_in    = opb_ff;
      acc_in    = acc_ff;
      prod_in   = {32'b0, mul_a} * {32'b0, mul_b};
      mcnt_in   = mcnt_ff;
      rem_in    = rem_ff;
      q_in      = q_ff;
      num_in    = num_ff;
      dcnt_in   = dcnt_ff;
      rt_in     = rt_ff;
      rb_in     = rb_ff;
      iter_in   = iter_ff;
      status_in = status_ff;
      flag_in   = flag_ff;
      done_in   = 1'b0;
      ep_in     = ep_ff;
      tp_in     = tp_ff;
      wr_en     = 1'b0;
      wr_dst    = dst_ff;
      wr_data   = '0;
      unique case (state_ff)
         D_IDLE: begin
            if (cmd.start) begin
               op_in    = cmd.op;
               b_in     = cmd.b;
               dst_in   = cmd.dst;
               state_in = D_FB;
            end
         end
         D_FB: begin
            opa_in   = sel_data;
            state_in = D_LB;
         end
         D_LB: begin
            opb_in   = sel_data;
            state_in = D_EXEC;
         end
         D_EXEC: begin
            state_in = D_IDLE;
            done_in  = 1'b1;
            unique case (op_ff)
               OP_ADD: begin
                  wr_en   = 1'b1;
                  wr_data = fx_add(opa_ff, opb_ff);
                  flag_in = (wr_data == '0);
               end
               OP_MUL: begin
                  done_in  = 1'b0;
                  mcnt_in  = '0;
                  state_in = D_MUL;
               end
               OP_DIV: begin
                  if (opb_ff == '0 || {32'b0, opa_ff[63:32]} >= opb_ff) begin
                     wr_en   = 1'b1;
                     wr_data = FX_SAT;
                     flag_in = 1'b0;
                  end else begin
                     done_in  = 1'b0;
                     rem_in   = '0;
                     q_in     = '0;
                     num_in   = opa_ff;
                     dcnt_in  = '0;
                     state_in = D_DIV;
                  end
               end
               OP_ABSDIF: begin
                  wr_en   = 1'b1;
                  wr_data = (opa_ff > opb_ff) ? opa_ff - opb_ff : opb_ff - opa_ff;
                  flag_in = (wr_data == '0);
               end
               OP_LT:    flag_in = (opa_ff < opb_ff);
               OP_RINIT: begin
                  rt_in = '0;
                  rb_in = 6'(RootTop);
               end
               OP_RCAND: begin
                  wr_en   = 1'b1;
                  wr_data = {24'b0, rt_ff} | rbit;
               end
               OP_RSTEP: begin
                  if (opa_ff <= opb_ff) rt_in = rt_ff | rbit[RootTop:0];
                  flag_in = (rb_ff != '0);
                  rb_in   = rb_ff - 1'b1;
               end
               OP_RGET: begin
                  wr_en   = 1'b1;
                  wr_data = {24'b0, rt_ff};
               end
               OP_ITINC: iter_in   = iter_ff + 1'b1;
               OP_ITCHK: flag_in   = (iter_ff == IterMax);
               OP_ST0:   status_in = ST_CONVERGED;
               OP_ST1:   status_in = ST_LIMIT;
               default:  flag_in   = flag_ff;
            endcase
         end
         D_MUL: begin
            mcnt_in = mcnt_ff + 1'b1;
            unique case (mcnt_ff)
               3'd0: acc_in = acc_ff;
               3'd1: acc_in = (prod_ff[63:32] != '0) ? FX_SAT : {prod_ff[31:0], 32'b0};
               3'd2, 3'd3: acc_in = fx_add(acc_ff, prod_ff);
               default: begin
                  wr_en    = 1'b1;
                  wr_data  = fx_add(acc_ff, {32'b0, prod_ff[63:32]});
                  flag_in  = (wr_data == '0);
                  done_in  = 1'b1;
                  state_in = D_IDLE;
               end
            endcase
         end
         D_DIV: begin
            num_in  = {num_ff[FxW-2:0], 1'b0};
            rem_in  = take ? r2 - opb_ff : r2;
            q_in    = {q_ff[FxW-2:0], take};
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == 7'(DivLast)) begin
               wr_en    = 1'b1;
               wr_data  = q_in;
               flag_in  = (q_in == '0);
               done_in  = 1'b1;
               state_in = D_IDLE;
            end
         end
         default: state_in = D_IDLE;
      endcase
      if (wr_en && wr_dst == S_EP) ep_in = wr_data;
      if (wr_en && wr_dst == S_TP) tp_in = wr_data;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
         flag_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         flag_ff  <= flag_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      b_ff    <= b_in;
      dst_ff  <= dst_in;
      opa_ff  <= opa_in;
      opb_ff  <= opb_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      mcnt_ff <= mcnt_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      num_ff  <= num_in;
      dcnt_ff <= dcnt_in;
      rt_ff   <= rt_in;
      rb_ff   <= rb_in;
      ep_ff   <= ep_in;
      tp_ff   <= tp_in;
      if (state_ff == D_IDLE && cmd.start) a_hold_ff <= cmd.a;
      if (cmd.load) begin
         iter_ff   <= 6'd1;
         status_ff <= ST_SINGULAR;
      end else begin
         iter_ff   <= iter_in;
         status_ff <= status_in;
      end
   end

   assign sts.done = done_ff;
   assign sts.flag = flag_ff;

   always_comb begin
      res.cell_id         = tag_ff;
      res.energy_out      = to_out(ep_ff);
      res.temperature_out = to_out(tp_ff);
      res.iterations      = iter_ff;
      res.status          = status_ff;
   end

endmodule

// ===== design/radiation_matter_relaxation_solver_core.sv =====
// radiation_matter_relaxation_solver_core: top level, stream ports and csr write port
// depends on rmrs_pkg, rmrs_ctrl and rmrs_datapath

// One cell per beat. The solver takes a cell, runs fixed-point passes of the implicit
// radiation-matter relaxation and returns one result beat, then takes the next cell.
// Every operation runs on one shared datapath: a 32x32 multiplier for q32.32 products,
// a one-bit-per-cycle divider and a bit-by-bit fourth root (40 rounds of two products).
// A pass's time is set mostly by the root and the five divisions, and an item runs from
// an early exit on zero temperature up to MAX_ITER passes. The user must write registers
// through the csr port only while no cell is in flight; the block itself does not enforce
// this.

module radiation_matter_relaxation_solver_core
   import rmrs_pkg::*;
#(
   parameter int MAX_ITER = 25
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // cell_tag[15:0], energy_in[47:16], temperature_in[79:48], absorption[111:80],
   // scaling_eps[143:112]
   input  logic [143:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // cell_id[15:0], energy_out[47:16], temperature_out[79:48], iterations[85:80],
   // status[87:86]
   output logic [87:0]  rsp_tdata,
   input  logic         csr_wen,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   cmd_type    cmd;
   sts_type    sts;
   result_type res;

   rmrs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   rmrs_datapath #(
      .MAX_ITER (MAX_ITER)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cell_tag       (req_tdata[15:0]),
      .energy_in      (req_tdata[47:16]),
      .temperature_in (req_tdata[79:48]),
      .absorption     (req_tdata[111:80]),
      .scaling_eps    (req_tdata[143:112]),
      .cmd            (cmd),
      .sts            (sts),
      .res            (res)
   );

   // result beat layout
   assign rsp_tdata = {res.status, res.iterations, res.temperature_out, res.energy_out,
                       res.cell_id};

endmodule
